### rtl/tmbm_pkg.sv
// Shared types and constants of the trimmed-mean battery monitor.
// Used by the channel interfaces and every module of the block; no dependencies.
`default_nettype none

package tmbm_pkg;

  localparam int SAMPLE_W    = 10;
  localparam int LEVEL_W     = 9;
  localparam int FS_W        = 16;
  localparam int DIV_W       = 19;
  localparam int DIVISOR_W   = 16;
  localparam int APB_ADDR_W  = 3;
  localparam int APB_DATA_W  = 32;

  localparam int LEVEL_SCALE = 420;
  localparam int LEVEL_LIMIT = 500;
  localparam int TRIM_COUNT  = 2;

  localparam logic [FS_W-1:0] FULL_SCALE_RESET = 16'd1023;
  // register index of full_scale, taken from paddr[2]
  localparam logic REG_FULL_SCALE = 1'b0;

  typedef enum logic {
    DIV_MEAN  = 1'b0,
    DIV_LEVEL = 1'b1
  } div_sel_e;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                last;
  } sample_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] trimmed_mean;
    logic [SAMPLE_W-1:0] smoothed_raw;
    logic [LEVEL_W-1:0]  battery_level;
    logic                overrun;
  } result_t;

  typedef struct packed {
    logic     acc_en;
    logic     div_start;
    div_sel_e div_sel;
    logic     mean_div;
    logic     mean_first;
    logic     smooth_en;
    logic     prod_en;
    logic     level_div;
    logic     level_zero;
    logic     emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic trim_ok;
    logic fs_zero;
    logic div_done;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

### rtl/tmbm_sample_if.sv
// Sample channel: valid/ready handshake carrying one ADC sample and its last flag.
// Depends on tmbm_pkg for the payload type.
`default_nettype none

interface tmbm_sample_if import tmbm_pkg::*; ;
  logic    valid;
  logic    ready;
  sample_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

### rtl/tmbm_result_if.sv
// Result channel: valid/ready handshake carrying one burst result.
// Depends on tmbm_pkg for the payload type.
`default_nettype none

interface tmbm_result_if import tmbm_pkg::*; ;
  logic    valid;
  logic    ready;
  result_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

### rtl/trimmed_mean_battery_monitor_core.sv
// Trimmed-mean battery monitor, top level.
// Channels: in_ch (sink) takes 10-bit ADC samples with a last flag; out_ch
// (source) gives one result per closed burst: trimmed mean, smoothed raw
// reading, battery level in hundredths of a volt and an overrun flag.
// Samples beyond MAX_BURST in one burst are dropped and flag overrun.
// A sample without last is taken in the idle state and in_ch.ready stays high.
// A closing sample starts the result sequence: up to two passes of the
// shared restoring divider (start, one shift per quotient bit, done), mean
// first, then value*420/full_scale; in_ch.ready stays low from the closing
// transfer until the result is loaded into the output register.
// The result sits in an output register; while the receiver stalls, the next
// burst is collected, and its result waits with in_ch.ready low until the
// register frees.
// full_scale is written over the APB port at address 0 (reset 1023).
// Reset clears the burst state, the smoothed reading and the output valid.
// Depends on tmbm_pkg, both channel interfaces, tmbm_ctrl, tmbm_dp, tmbm_div.
`default_nettype none

module trimmed_mean_battery_monitor_core import tmbm_pkg::*; #(
  parameter int MAX_BURST = 4
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  tmbm_sample_if.sink                in_ch,
  tmbm_result_if.source              out_ch,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready
);

  logic [FS_W-1:0] fs_q;
  logic            fs_sel;
  ctrl_cmd_t       cmd;
  dp_sts_t         sts;

  assign pready = 1'b1;
  assign fs_sel = (paddr[2] == REG_FULL_SCALE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fs_q <= FULL_SCALE_RESET;
    end else if (psel && penable && pwrite && fs_sel) begin
      fs_q <= pwdata[FS_W-1:0];
    end
  end

  assign prdata = fs_sel ? APB_DATA_W'(fs_q) : '0;

  tmbm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .in_last_i  (in_ch.payload.last),
    .in_ready_o (in_ch.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tmbm_dp #(
    .MAX_BURST (MAX_BURST)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .sample_i    (in_ch.payload.sample),
    .fs_i        (fs_q),
    .out_ready_i (out_ch.ready),
    .out_valid_o (out_ch.valid),
    .result_o    (out_ch.payload)
  );

endmodule

`default_nettype wire

### rtl/tmbm_div.sv
// Restoring divider, one quotient bit per cycle, shared by the mean and level paths.
// Depends on tmbm_pkg for operand widths.
`default_nettype none

module tmbm_div import tmbm_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [DIV_W-1:0]     dividend_i,
  input  wire logic [DIVISOR_W-1:0] divisor_i,
  output logic                      done_o,
  output logic [DIV_W-1:0]          quotient_o
);

  localparam int STEP_W = $clog2(DIV_W + 1);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [STEP_W-1:0]    step_q, step_d;
  logic [DIV_W-1:0]     quo_q, quo_d;
  logic [DIVISOR_W-1:0] rem_q, rem_d;
  logic [DIVISOR_W-1:0] dsr_q, dsr_d;
  logic [DIVISOR_W:0]   trial;
  logic [DIVISOR_W:0]   diff;

  assign trial = {rem_q, quo_q[DIV_W-1]};
  assign diff  = trial - {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = STEP_W'(DIV_W);
      quo_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      // shift in the next dividend bit, subtract when it fits
      if (trial >= {1'b0, dsr_q}) begin
        rem_d = diff[DIVISOR_W-1:0];
        quo_d = {quo_q[DIV_W-2:0], 1'b1};
      end else begin
        rem_d = trial[DIVISOR_W-1:0];
        quo_d = {quo_q[DIV_W-2:0], 1'b0};
      end
      step_d = step_q - STEP_W'(1);
      if (step_q == STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

### rtl/tmbm_dp.sv
// Datapath: burst accumulators, mean, smoothing, level scaling and the result register.
// Depends on tmbm_pkg and tmbm_div; driven by commands from tmbm_ctrl.
`default_nettype none

module tmbm_dp import tmbm_pkg::*; #(
  parameter int MAX_BURST = 4
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire ctrl_cmd_t           cmd_i,
  output dp_sts_t                  sts_o,
  input  wire logic [SAMPLE_W-1:0] sample_i,
  input  wire logic [FS_W-1:0]     fs_i,
  input  wire logic                out_ready_i,
  output logic                     out_valid_o,
  output result_t                  result_o
);

  localparam int CNT_W = $clog2(MAX_BURST + 1);
  localparam int SUM_W = SAMPLE_W + CNT_W;

  logic [CNT_W-1:0]    cnt_q;
  logic [SUM_W-1:0]    sum_q;
  logic [SAMPLE_W-1:0] min_q, max_q, first_q;
  logic                ovr_q;
  logic [SAMPLE_W-1:0] mean_q;
  logic [SAMPLE_W-1:0] sv_q;
  logic [DIV_W-1:0]    prod_q;
  logic [LEVEL_W-1:0]  level_q;
  logic                out_valid_q, out_valid_d;
  result_t             out_q;

  logic [7:0]           cnt_x;
  logic                 has_room;
  logic [SUM_W-1:0]     trimmed_sum;
  logic [SAMPLE_W:0]    avg_sum;
  logic [SAMPLE_W-1:0]  sv_next;
  logic [SAMPLE_W-1:0]  clamped;
  logic [DIV_W-1:0]     div_dividend;
  logic [DIVISOR_W-1:0] div_divisor;
  logic                 div_done;
  logic [DIV_W-1:0]     div_quo;
  logic                 out_free;

  assign cnt_x       = 8'(cnt_q);
  assign has_room    = cnt_x < 8'(MAX_BURST);
  assign trimmed_sum = sum_q - SUM_W'(max_q) - SUM_W'(min_q);

  assign div_dividend = (cmd_i.div_sel == DIV_MEAN) ? DIV_W'(trimmed_sum) : prod_q;
  assign div_divisor  = (cmd_i.div_sel == DIV_MEAN) ?
                        DIVISOR_W'(cnt_x - 8'(TRIM_COUNT)) : fs_i;

  tmbm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign avg_sum = {1'b0, mean_q} + {1'b0, sv_q};
  assign sv_next = (sv_q != '0) ? avg_sum[SAMPLE_W:1] : mean_q;
  assign clamped = (FS_W'(sv_q) > fs_i) ? fs_i[SAMPLE_W-1:0] : sv_q;

  assign out_free = !out_valid_q || out_ready_i;

  // burst accumulators
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      sum_q   <= '0;
      min_q   <= '0;
      max_q   <= '0;
      first_q <= '0;
      ovr_q   <= 1'b0;
    end else if (cmd_i.emit) begin
      cnt_q   <= '0;
      sum_q   <= '0;
      min_q   <= '0;
      max_q   <= '0;
      first_q <= '0;
      ovr_q   <= 1'b0;
    end else if (cmd_i.acc_en) begin
      if (has_room) begin
        if (cnt_q == '0) begin
          first_q <= sample_i;
          min_q   <= sample_i;
          max_q   <= sample_i;
        end else begin
          if (sample_i < min_q) min_q <= sample_i;
          if (sample_i > max_q) max_q <= sample_i;
        end
        sum_q <= sum_q + SUM_W'(sample_i);
        cnt_q <= cnt_q + CNT_W'(1);
      end else begin
        ovr_q <= 1'b1;
      end
    end
  end

  // smoothed reading survives bursts
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q <= '0;
    end else if (cmd_i.smooth_en) begin
      sv_q <= sv_next;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mean_div) begin
      mean_q <= div_quo[SAMPLE_W-1:0];
    end else if (cmd_i.mean_first) begin
      mean_q <= first_q;
    end
    if (cmd_i.prod_en) begin
      prod_q <= DIV_W'(clamped) * DIV_W'(LEVEL_SCALE);
    end
    if (cmd_i.level_div) begin
      level_q <= (div_quo > DIV_W'(LEVEL_LIMIT)) ? LEVEL_W'(LEVEL_LIMIT)
                                                 : div_quo[LEVEL_W-1:0];
    end else if (cmd_i.level_zero) begin
      level_q <= '0;
    end
    if (cmd_i.emit) begin
      out_q.trimmed_mean  <= mean_q;
      out_q.smoothed_raw  <= sv_q;
      out_q.battery_level <= level_q;
      out_q.overrun       <= ovr_q;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign sts_o.trim_ok  = cnt_x > 8'(TRIM_COUNT);
  assign sts_o.fs_zero  = (fs_i == '0);
  assign sts_o.div_done = div_done;
  assign sts_o.out_free = out_free;

  assign out_valid_o = out_valid_q;
  assign result_o    = out_q;

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_x <= 8'(MAX_BURST))
    else $error("sample count above burst bound");

  a_emit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |=> out_valid_q && (cnt_q == '0) && !ovr_q)
    else $error("emit did not load result and clear burst");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> out_free)
    else $error("result overwritten before transfer");
`endif

endmodule

`default_nettype wire

### rtl/tmbm_ctrl.sv
// Controller: sequences accumulate, mean division, smoothing, level division and emit.
// Depends on tmbm_pkg for the command and status structs.
`default_nettype none

module tmbm_ctrl import tmbm_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  input  wire logic    in_last_i,
  output logic         in_ready_o,
  input  wire dp_sts_t sts_i,
  output ctrl_cmd_t    cmd_o
);

  localparam logic [2:0] ST_IDLE       = 3'd0;
  localparam logic [2:0] ST_MEAN       = 3'd1;
  localparam logic [2:0] ST_MEAN_WAIT  = 3'd2;
  localparam logic [2:0] ST_SMOOTH     = 3'd3;
  localparam logic [2:0] ST_PROD       = 3'd4;
  localparam logic [2:0] ST_LEVEL      = 3'd5;
  localparam logic [2:0] ST_LEVEL_WAIT = 3'd6;
  localparam logic [2:0] ST_EMIT       = 3'd7;

  logic [2:0] state_q, state_d;
  ctrl_cmd_t  cmd;

  always_comb begin
    state_d = state_q;
    cmd     = '0;
    cmd.div_sel = DIV_MEAN;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd.acc_en = 1'b1;
          if (in_last_i) state_d = ST_MEAN;
        end
      end
      ST_MEAN: begin
        if (sts_i.trim_ok) begin
          cmd.div_start = 1'b1;
          state_d       = ST_MEAN_WAIT;
        end else begin
          cmd.mean_first = 1'b1;
          state_d        = ST_SMOOTH;
        end
      end
      ST_MEAN_WAIT: begin
        if (sts_i.div_done) begin
          cmd.mean_div = 1'b1;
          state_d      = ST_SMOOTH;
        end
      end
      ST_SMOOTH: begin
        cmd.smooth_en = 1'b1;
        state_d       = ST_PROD;
      end
      ST_PROD: begin
        cmd.prod_en = 1'b1;
        state_d     = ST_LEVEL;
      end
      ST_LEVEL: begin
        cmd.div_sel = DIV_LEVEL;
        if (sts_i.fs_zero) begin
          cmd.level_zero = 1'b1;
          state_d        = ST_EMIT;
        end else begin
          cmd.div_start = 1'b1;
          state_d       = ST_LEVEL_WAIT;
        end
      end
      ST_LEVEL_WAIT: begin
        cmd.div_sel = DIV_LEVEL;
        if (sts_i.div_done) begin
          cmd.level_div = 1'b1;
          state_d       = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // hold until the result register is free
        if (sts_i.out_free) begin
          cmd.emit = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign cmd_o      = cmd;

`ifndef ASSERT_OFF
  a_mean_div_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.div_start && cmd.div_sel == DIV_MEAN) |-> sts_i.trim_ok)
    else $error("mean division started with too few samples");

  a_level_div_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.div_start && cmd.div_sel == DIV_LEVEL) |-> !sts_i.fs_zero)
    else $error("level division started with zero full scale");

  a_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.div_done |-> (state_q == ST_MEAN_WAIT || state_q == ST_LEVEL_WAIT))
    else $error("divider finished outside a wait state");
`endif

endmodule

`default_nettype wire

### tb/tmbm_burst_checker.sv
`timescale 1ns / 100ps
// Result checker of the trimmed-mean battery monitor: watches both channels and the
// APB port, keeps its own burst and smoothing state, and compares every result.
// Depends on tmbm_pkg and the two channel interfaces.

module tmbm_burst_checker import tmbm_pkg::*; #(
  parameter int MAX_BURST = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  tmbm_sample_if                samp,
  tmbm_result_if                res,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  input  logic [APB_DATA_W-1:0] prdata,
  input  logic                  pready,
  output int                    mismatches,
  output int                    pending
);

  logic [FS_W-1:0]     full_scale;
  int unsigned         burst_len;
  int unsigned         burst_sum;
  logic [SAMPLE_W-1:0] burst_min;
  logic [SAMPLE_W-1:0] burst_max;
  logic [SAMPLE_W-1:0] burst_first;
  logic [SAMPLE_W-1:0] smoothed;
  logic                dropped;
  result_t             readings_q[$];

  function automatic logic [LEVEL_W-1:0] scale_level(logic [SAMPLE_W-1:0] raw,
                                                     logic [FS_W-1:0] fs);
    int unsigned clamped;
    int unsigned lvl;
    if (fs == '0) begin
      return '0;
    end
    clamped = (raw > fs) ? fs : raw;
    lvl = clamped * LEVEL_SCALE / fs;
    if (lvl > LEVEL_LIMIT) begin
      lvl = LEVEL_LIMIT;
    end
    return lvl[LEVEL_W-1:0];
  endfunction

  // Fold one accepted sample into the burst; a closing sample queues a reading.
  function automatic void absorb_sample(sample_t item);
    int unsigned mean;
    result_t     reading;
    if (burst_len < MAX_BURST) begin
      if (burst_len == 0) begin
        burst_first = item.sample;
        burst_min   = item.sample;
        burst_max   = item.sample;
      end else begin
        if (item.sample < burst_min) burst_min = item.sample;
        if (item.sample > burst_max) burst_max = item.sample;
      end
      burst_sum += item.sample;
      burst_len++;
    end else begin
      dropped = 1'b1;
    end
    if (!item.last) begin
      return;
    end
    if (burst_len > TRIM_COUNT) begin
      mean = (burst_sum - burst_max - burst_min) / (burst_len - TRIM_COUNT);
    end else begin
      mean = burst_first;
    end
    mean = mean & 10'h3FF;
    if (smoothed != '0) begin
      smoothed = SAMPLE_W'((mean + smoothed) / 2);
    end else begin
      smoothed = SAMPLE_W'(mean);
    end
    reading.trimmed_mean  = SAMPLE_W'(mean);
    reading.smoothed_raw  = smoothed;
    reading.battery_level = scale_level(smoothed, full_scale);
    reading.overrun       = dropped;
    readings_q.push_back(reading);
    burst_len = 0;
    burst_sum = 0;
    burst_min = '0;
    burst_max = '0;
    burst_first = '0;
    dropped = 1'b0;
  endfunction

  function automatic void report(string what);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s", $time, what);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t got;
    result_t want;
    if (!rst_ni) begin
      full_scale  = FULL_SCALE_RESET;
      burst_len   = 0;
      burst_sum   = 0;
      burst_min   = '0;
      burst_max   = '0;
      burst_first = '0;
      smoothed    = '0;
      dropped     = 1'b0;
      mismatches  = 0;
      readings_q.delete();
      pending <= 0;
    end else begin
      // Drain first: a result never leaves in the cycle of its own closing sample.
      if (res.valid && res.ready) begin
        got = res.payload;
        if (readings_q.size() == 0) begin
          report($sformatf("unexpected result mean=%0d smooth=%0d level=%0d ovr=%0d",
                           got.trimmed_mean, got.smoothed_raw, got.battery_level,
                           got.overrun));
        end else begin
          want = readings_q.pop_front();
          if (got.trimmed_mean !== want.trimmed_mean ||
              got.smoothed_raw !== want.smoothed_raw ||
              got.battery_level !== want.battery_level ||
              got.overrun !== want.overrun) begin
            report($sformatf({"result mismatch: expected mean=%0d smooth=%0d level=%0d ",
                              "ovr=%0d, got mean=%0d smooth=%0d level=%0d ovr=%0d"},
                             want.trimmed_mean, want.smoothed_raw, want.battery_level,
                             want.overrun, got.trimmed_mean, got.smoothed_raw,
                             got.battery_level, got.overrun));
          end
        end
      end
      if (samp.valid && samp.ready) begin
        absorb_sample(samp.payload);
      end
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr[2] == REG_FULL_SCALE) full_scale = pwdata[FS_W-1:0];
        end else if (prdata !== APB_DATA_W'(full_scale)) begin
          report($sformatf("full_scale readback: expected %0d, got %0d",
                           full_scale, prdata));
        end
      end
      pending <= readings_q.size();
    end
  end

endmodule

### tb/tb_trimmed_mean_battery_monitor_core.sv
`timescale 1ns / 100ps
// Testbench top of the trimmed-mean battery monitor: clock, reset, sample bursts,
// receiver stalls and full_scale writes over APB; the verdict comes from tmbm_burst_checker.
// Depends on tmbm_pkg, both channel interfaces, the core and the checker.

module tb_trimmed_mean_battery_monitor_core;
  import tmbm_pkg::*;

  localparam int MAX_BURST    = 4;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 150;
  localparam int DRAIN_CYCLES = 60;
  localparam int IDLE_PCT     = 18;
  localparam logic [APB_ADDR_W-1:0] FULL_SCALE_ADDR = {REG_FULL_SCALE, 2'b00};

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  bit                    steady;
  int                    mismatches;
  int                    pending;

  tmbm_sample_if sample_ch ();
  tmbm_result_if result_ch ();

  trimmed_mean_battery_monitor_core #(.MAX_BURST(MAX_BURST)) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_ch   (sample_ch),
    .out_ch  (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  tmbm_burst_checker #(.MAX_BURST(MAX_BURST)) u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .samp       (sample_ch),
    .res        (result_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always #6 clk_i = ~clk_i;

  // Receiver: stall at random unless the phase runs steady.
  initial begin
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      result_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  task automatic send_sample(input logic [SAMPLE_W-1:0] value, input logic closing);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    sample_ch.valid   <= 1'b1;
    sample_ch.payload <= '{sample: value, last: closing};
    do @(posedge clk_i); while (!sample_ch.ready);
  endtask

  // Hold off until every queued reading has arrived and the core has settled.
  task automatic wait_drained();
    sample_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_access(input logic wr, input logic [APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= FULL_SCALE_ADDR;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample(int center);
    int v;
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3:    return SAMPLE_W'($urandom);
      default: begin
        v = center + $urandom_range(64) - 32;
        if (v < 0) v = 0;
        if (v > 1023) v = 1023;
        return SAMPLE_W'(v);
      end
    endcase
  endfunction

  // Mostly well-formed bursts; some overrun the bound, a few are all zero.
  task automatic send_burst(output int len);
    int center;
    bit zeros;
    len    = ($urandom_range(99) < 15) ? $urandom_range(MAX_BURST + 3, MAX_BURST + 1)
                                       : $urandom_range(MAX_BURST, 1);
    center = $urandom_range(1023);
    zeros  = ($urandom_range(99) < 5);
    for (int i = 0; i < len; i++) begin
      send_sample(zeros ? '0 : pick_sample(center), i == len - 1);
    end
  endtask

  task automatic run_phase(input int phase);
    int sent;
    int len;
    bit paused;
    sent   = 0;
    paused = 1'b0;
    while (sent < PHASE_ITEMS) begin
      send_burst(len);
      sent += len;
      if (phase == 4 && !paused && sent >= PHASE_ITEMS / 2) begin
        wait_drained();
        paused = 1'b1;
      end
    end
  endtask

  initial begin
    logic [FS_W-1:0] fs;
    rst_ni            <= 1'b0;
    sample_ch.valid   <= 1'b0;
    sample_ch.payload <= '0;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    apb_access(1'b0, '0);
    // zero mean keeps the stored reading at zero, so the next mean is taken as is
    send_sample(10'd0, 1'b1);
    send_sample(10'd1023, 1'b1);
    // two samples: first sample wins
    send_sample(10'd5, 1'b0);
    send_sample(10'd900, 1'b1);
    send_sample(10'd1023, 1'b0);
    send_sample(10'd0, 1'b0);
    send_sample(10'd512, 1'b1);
    send_sample(10'd100, 1'b0);
    send_sample(10'd200, 1'b0);
    send_sample(10'd300, 1'b0);
    send_sample(10'd400, 1'b1);
    // burst too long, closing on a dropped sample
    send_sample(10'd7, 1'b0);
    send_sample(10'd1023, 1'b0);
    send_sample(10'd0, 1'b0);
    send_sample(10'd3, 1'b0);
    send_sample(10'd9, 1'b0);
    send_sample(10'd11, 1'b1);
    send_sample(10'd1, 1'b0);
    send_sample(10'd2, 1'b0);
    send_sample(10'd3, 1'b0);
    send_sample(10'd4, 1'b0);
    send_sample(10'd500, 1'b1);
    // widest sum
    send_sample(10'd1023, 1'b0);
    send_sample(10'd1023, 1'b0);
    send_sample(10'd1023, 1'b0);
    send_sample(10'd1023, 1'b1);
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       fs = 16'd1;
        1:       fs = 16'hFFFF;
        2:       fs = 16'd0;
        3:       fs = FULL_SCALE_RESET;
        4:       fs = 16'd300;
        5, 6:    fs = FS_W'($urandom_range(2047, 1));
        default: fs = FS_W'($urandom_range(65535, 1));
      endcase
      steady = (p == 3);
      apb_access(1'b1, APB_DATA_W'(fs));
      apb_access(1'b0, '0);
      run_phase(p);
      wait_drained();
    end

    if (mismatches == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

### files.f
rtl/tmbm_pkg.sv
rtl/tmbm_sample_if.sv
rtl/tmbm_result_if.sv
rtl/tmbm_div.sv
rtl/tmbm_dp.sv
rtl/tmbm_ctrl.sv
rtl/trimmed_mean_battery_monitor_core.sv
tb/tmbm_burst_checker.sv
tb/tb_trimmed_mean_battery_monitor_core.sv
